>>> src/atp_pkg.sv
`default_nettype none
package atp_pkg;

  localparam int TABLE_DEPTH_DEF = 64;
  localparam int QUEUE_DEPTH     = 2;
  localparam int ID_W            = 32;
  localparam int SIZE_W          = 40;
  localparam int USAGE_W         = 48;
  localparam int COUNT_W         = 32;
  localparam int MIB_SHIFT       = 20;
  localparam int MIB_W           = USAGE_W - MIB_SHIFT;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_UPDATE,
    S_REPORT
  } bstate_t;

  typedef struct packed {
    logic                     req_type;
    logic signed [ID_W-1:0]   alloc_id;
    logic        [SIZE_W-1:0] alloc_size;
  } in_req_t;

  typedef struct packed {
    logic               matched;
    logic               table_full;
    logic [USAGE_W-1:0] usage_bytes;
    logic [USAGE_W-1:0] peak_bytes;
    logic [MIB_W-1:0]   peak_mib;
    logic [COUNT_W-1:0] alloc_events;
    logic [COUNT_W-1:0] free_events;
  } out_res_t;

  typedef struct packed {
    op_t               op;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } cmd_t;

  typedef struct packed {
    logic live;
    logic [ID_W-1:0]   id;
    logic [SIZE_W-1:0] size;
  } slot_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } front_out_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage
`default_nettype wire

>>> src/atp_front.sv
`default_nettype none
module atp_front
  import atp_pkg::*;
(
  input  wire        clk,
  input  wire        rst_n,
  input  wire        start,
  output logic       busy,
  input  in_req_t    in_req,
  input  back_ctl_t  ctl,
  output front_out_t fo
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             q_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             push;
  logic             pop;
  cmd_t             cmd_in;

  assign busy = (count_r == CNT_W'(QUEUE_DEPTH)) || ctl.clearing;
  assign push = start && !busy;
  assign pop  = ctl.pop && (count_r != '0);

  always_comb begin
    cmd_in.op   = in_req.req_type ? OP_FREE : OP_ALLOC;
    cmd_in.id   = in_req.alloc_id;
    cmd_in.size = in_req.alloc_size;
  end

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= cmd_in;
    end
  end

  assign fo.valid = (count_r != '0);
  assign fo.cmd   = q_r[rd_ptr_r];

endmodule
`default_nettype wire

>>> src/atp_back.sv
`default_nettype none
module atp_back
  import atp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  input  front_out_t fo,
  output back_ctl_t  ctl,
  output logic       out_strobe,
  output out_res_t   out_res
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  slot_t              mem_r [TABLE_DEPTH];
  slot_t              rd_data_r;
  logic               mem_we;
  logic [AW-1:0]      mem_wa;
  slot_t              mem_wd;

  bstate_t            state_r, state_nxt;
  logic [AW:0]        iss_r, iss_nxt;
  logic               rdv_r, rdv_nxt;
  logic [AW-1:0]      rdidx_r, rdidx_nxt;
  cmd_t               cur_r, cur_nxt;
  logic               found_r, found_nxt;
  logic [AW-1:0]      hit_idx_r, hit_idx_nxt;
  logic [SIZE_W-1:0]  hit_size_r, hit_size_nxt;
  logic [USAGE_W-1:0] live_r, live_nxt;
  logic [USAGE_W-1:0] peak_r, peak_nxt;
  logic [COUNT_W-1:0] alloc_cnt_r, alloc_cnt_nxt;
  logic [COUNT_W-1:0] free_cnt_r, free_cnt_nxt;
  logic               matched_r, matched_nxt;
  logic               full_r, full_nxt;
  logic               out_strobe_r, out_strobe_nxt;
  out_res_t           out_res_r, out_res_nxt;
  logic               hit;
  logic [USAGE_W:0]   sum;

  assign hit = (cur_r.op == OP_ALLOC) ? !rd_data_r.live
             : (rd_data_r.live && (rd_data_r.id == cur_r.id));
  assign sum = {1'b0, live_r} + {{(USAGE_W - SIZE_W + 1){1'b0}}, cur_r.size};

  always_comb begin
    state_nxt      = state_r;
    iss_nxt        = iss_r;
    rdv_nxt        = 1'b0;
    rdidx_nxt      = rdidx_r;
    cur_nxt        = cur_r;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_size_nxt   = hit_size_r;
    live_nxt       = live_r;
    peak_nxt       = peak_r;
    alloc_cnt_nxt  = alloc_cnt_r;
    free_cnt_nxt   = free_cnt_r;
    matched_nxt    = matched_r;
    full_nxt       = full_r;
    out_strobe_nxt = 1'b0;
    out_res_nxt    = out_res_r;
    mem_we         = 1'b0;
    mem_wa         = hit_idx_r;
    mem_wd         = '0;
    ctl.pop        = 1'b0;
    ctl.clearing   = (state_r == S_CLEAR);

    case (state_r)
      S_CLEAR: begin
        mem_we  = 1'b1;
        mem_wa  = iss_r[AW-1:0];
        iss_nxt = iss_r + 1'b1;
        if (iss_r == (AW+1)'(TABLE_DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (fo.valid) begin
          ctl.pop   = 1'b1;
          cur_nxt   = fo.cmd;
          iss_nxt   = '0;
          found_nxt = 1'b0;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (iss_r < (AW+1)'(TABLE_DEPTH)) begin
          rdv_nxt   = 1'b1;
          rdidx_nxt = iss_r[AW-1:0];
          iss_nxt   = iss_r + 1'b1;
        end
        if (rdv_r && hit) begin
          rdv_nxt      = 1'b0;
          found_nxt    = 1'b1;
          hit_idx_nxt  = rdidx_r;
          hit_size_nxt = rd_data_r.size;
          state_nxt    = S_UPDATE;
        end else if (rdv_r && (rdidx_r == AW'(TABLE_DEPTH - 1))) begin
          rdv_nxt   = 1'b0;
          state_nxt = S_UPDATE;
        end
      end
      S_UPDATE: begin
        mem_wa = hit_idx_r;
        if (cur_r.op == OP_ALLOC) begin
          alloc_cnt_nxt = alloc_cnt_r + 1'b1;
          matched_nxt   = 1'b0;
          full_nxt      = !found_r;
          if (found_r) begin
            mem_we      = 1'b1;
            mem_wd.live = 1'b1;
            mem_wd.id   = cur_r.id;
            mem_wd.size = cur_r.size;
            live_nxt    = sum[USAGE_W] ? '1 : sum[USAGE_W-1:0];
          end
        end else begin
          free_cnt_nxt = free_cnt_r + 1'b1;
          matched_nxt  = found_r;
          full_nxt     = 1'b0;
          if (found_r) begin
            mem_we = 1'b1;
            if ({{(USAGE_W - SIZE_W){1'b0}}, hit_size_r} >= live_r) begin
              live_nxt = '0;
            end else begin
              live_nxt = live_r - {{(USAGE_W - SIZE_W){1'b0}}, hit_size_r};
            end
          end
        end
        state_nxt = S_REPORT;
      end
      S_REPORT: begin
        if (live_r > peak_r) begin
          peak_nxt = live_r;
        end
        out_strobe_nxt           = 1'b1;
        out_res_nxt.matched      = matched_r;
        out_res_nxt.table_full   = full_r;
        out_res_nxt.usage_bytes  = live_r;
        out_res_nxt.peak_bytes   = peak_nxt;
        out_res_nxt.peak_mib     = peak_nxt[USAGE_W-1:MIB_SHIFT];
        out_res_nxt.alloc_events = alloc_cnt_r;
        out_res_nxt.free_events  = free_cnt_r;
        state_nxt                = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      iss_r        <= '0;
      rdv_r        <= 1'b0;
      live_r       <= '0;
      peak_r       <= '0;
      alloc_cnt_r  <= '0;
      free_cnt_r   <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      iss_r        <= iss_nxt;
      rdv_r        <= rdv_nxt;
      live_r       <= live_nxt;
      peak_r       <= peak_nxt;
      alloc_cnt_r  <= alloc_cnt_nxt;
      free_cnt_r   <= free_cnt_nxt;
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdidx_r    <= rdidx_nxt;
    cur_r      <= cur_nxt;
    found_r    <= found_nxt;
    hit_idx_r  <= hit_idx_nxt;
    hit_size_r <= hit_size_nxt;
    matched_r  <= matched_nxt;
    full_r     <= full_nxt;
    out_res_r  <= out_res_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem_r[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem_r[iss_r[AW-1:0]];
  end

  assign out_strobe = out_strobe_r;
  assign out_res    = out_res_r;

endmodule
`default_nettype wire

>>> src/allocation_tracker_peak.sv
// Allocation high-water tracker. A word is taken when start is high and busy is low; each
// word yields exactly one result, shown for a single cycle with out_strobe high, and the
// receiver cannot stall it. After reset the slot table is cleared one entry per cycle, so
// busy stays high until the clear is done. The back end then scans the slot table one entry
// per cycle through its single read port: a word's scan stops at the first slot that fits it,
// and a free of an unknown id or an alloc into a full table scans every slot.
// A two-word queue in front of the scanner lets new words be taken while one is in work.
`default_nettype none
module allocation_tracker_peak
  import atp_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  wire      clk,
  input  wire      rst_n,
  input  wire      start,
  output logic     busy,
  input  in_req_t  in_req,
  output logic     out_strobe,
  output out_res_t out_res
);

  front_out_t fo;
  back_ctl_t  ctl;

  atp_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .in_req(in_req),
    .ctl   (ctl),
    .fo    (fo)
  );

  atp_back #(
    .TABLE_DEPTH(TABLE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .fo        (fo),
    .ctl       (ctl),
    .out_strobe(out_strobe),
    .out_res   (out_res)
  );

endmodule
`default_nettype wire

>>> src/atp_checker.sv
`default_nettype none
module atp_checker
  import atp_pkg::*;
(
  input wire      clk,
  input wire      rst_n,
  input wire      start,
  input wire      busy,
  input in_req_t  in_req,
  input wire      out_strobe,
  input out_res_t out_res
);

  a_word_known: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> !$isunknown(in_req))
    else $error("word taken with unknown bits");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held for more than one cycle");

  a_peak_covers_usage: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.peak_bytes >= out_res.usage_bytes))
    else $error("peak below current usage");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_res.matched && out_res.table_full))
    else $error("matched and table_full both set");

  a_mib_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_res.peak_mib == out_res.peak_bytes[USAGE_W-1:MIB_SHIFT]))
    else $error("peak_mib disagrees with peak_bytes");

endmodule

bind allocation_tracker_peak atp_checker u_atp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_req    (in_req),
  .out_strobe(out_strobe),
  .out_res   (out_res)
);
`default_nettype wire
